// ===== hdl/hfic_pkg.sv =====
// shared types and constants for the half float / int16 converter
package hfic_pkg;

    localparam int unsigned WORD_W = 16;
    localparam int unsigned EXP_W  = 5;
    localparam int unsigned FRAC_W = 10;
    localparam int unsigned CNT_W  = 4;

    // exponent thresholds
    localparam logic [EXP_W-1:0] HALF_BIAS = 5'd15;
    localparam logic [EXP_W-1:0] INT_POINT = 5'd25;
    localparam logic [EXP_W-1:0] EXP_SAT   = 5'd30;
    localparam logic [EXP_W-1:0] EXP_ROUND = 5'd14;

    localparam logic [WORD_W-1:0] SAT_POS = 16'h7FFF;
    localparam logic [WORD_W-1:0] SAT_NEG = 16'h8000;

    localparam logic OP_H2I = 1'b0;
    localparam logic OP_I2H = 1'b1;

    typedef struct packed {
        logic              op;
        logic [WORD_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic [WORD_W-1:0] result;
        logic              overflow;
    } rsp_t;

    typedef struct packed {
        logic              load;
        logic              shl;
        logic              shr;
        logic [WORD_W-1:0] load_val;
    } shift_ctl_t;

    typedef struct packed {
        logic [WORD_W-1:0] w;
        logic              g;
        logic              s;
    } shift_stat_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

endpackage

// ===== hdl/hfic_shift_unit.sv =====
// shared one-bit shifter with guard and sticky tracking
module hfic_shift_unit (
    input  logic                clk,
    input  hfic_pkg::shift_ctl_t ctl,
    output hfic_pkg::shift_stat_t stat
);

    logic [hfic_pkg::WORD_W-1:0] w_reg, w_next;
    logic                        g_reg, g_next;
    logic                        s_reg, s_next;

    always_comb
    begin
        w_next = w_reg;
        g_next = g_reg;
        s_next = s_reg;
        if (ctl.load)
        begin
            w_next = ctl.load_val;
            g_next = 1'b0;
            s_next = 1'b0;
        end
        else if (ctl.shl)
        begin
            w_next = {w_reg[hfic_pkg::WORD_W-2:0], 1'b0};
        end
        else if (ctl.shr)
        begin
            // bits leaving the guard fold into sticky
            s_next = s_reg | g_reg;
            g_next = w_reg[0];
            w_next = {1'b0, w_reg[hfic_pkg::WORD_W-1:1]};
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg <= w_next;
        g_reg <= g_next;
        s_reg <= s_next;
    end

    assign stat.w = w_reg;
    assign stat.g = g_reg;
    assign stat.s = s_reg;

endmodule

// ===== hdl/hfic_seq.sv =====
// sequencer: decodes the operand, steps the shifter, packs the result
module hfic_seq (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  hfic_pkg::cmd_t        cmd,
    input  hfic_pkg::shift_stat_t stat,
    output hfic_pkg::shift_ctl_t  ctl,
    output logic                  busy,
    output logic                  fin,
    output hfic_pkg::rsp_t        fin_rsp
);

    hfic_pkg::state_t state_reg, state_next;
    logic [hfic_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic op_reg, op_next;
    logic sign_reg, sign_next;
    logic left_reg, left_next;
    logic fixed_reg, fixed_next;
    hfic_pkg::rsp_t fix_rsp_reg, fix_rsp_next;

    logic [hfic_pkg::EXP_W-1:0]  ex;
    logic [hfic_pkg::WORD_W-1:0] mag_in;
    logic                        rnd;
    logic [hfic_pkg::WORD_W-1:0] mag_out;
    logic [hfic_pkg::EXP_W-1:0]  exp_out;
    logic                        shifting;

    assign ex     = cmd.value[hfic_pkg::WORD_W-2 -: hfic_pkg::EXP_W];
    assign mag_in = cmd.value[hfic_pkg::WORD_W-1] ?
                    (hfic_pkg::WORD_W)'(16'd0 - cmd.value) : cmd.value;

    // round to nearest even from guard and sticky
    assign rnd     = stat.g & (stat.s | stat.w[0]);
    assign mag_out = stat.w + {{(hfic_pkg::WORD_W-1){1'b0}}, rnd};
    assign exp_out = hfic_pkg::EXP_SAT - {1'b0, cnt_reg};

    always_comb
    begin
        if (op_reg == hfic_pkg::OP_H2I)
            shifting = (cnt_reg != '0);
        else
            shifting = ~stat.w[hfic_pkg::WORD_W-1];
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        op_next      = op_reg;
        sign_next    = sign_reg;
        left_next    = left_reg;
        fixed_next   = fixed_reg;
        fix_rsp_next = fix_rsp_reg;
        ctl          = '0;
        fin          = 1'b0;
        fin_rsp      = '0;

        case (state_reg)
            hfic_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = hfic_pkg::ST_RUN;
                    op_next    = cmd.op;
                    sign_next  = cmd.value[hfic_pkg::WORD_W-1];
                    ctl.load   = 1'b1;
                    fixed_next = 1'b0;
                    left_next  = 1'b0;
                    cnt_next   = '0;
                    fix_rsp_next = '0;
                    if (cmd.op == hfic_pkg::OP_H2I)
                    begin
                        ctl.load_val = {5'b0, 1'b1, cmd.value[hfic_pkg::FRAC_W-1:0]};
                        if (ex >= hfic_pkg::EXP_SAT)
                        begin
                            // infinity, nan and magnitudes from 2^15 saturate
                            fixed_next = 1'b1;
                            fix_rsp_next.overflow = 1'b1;
                            fix_rsp_next.result = cmd.value[hfic_pkg::WORD_W-1] ?
                                                  hfic_pkg::SAT_NEG : hfic_pkg::SAT_POS;
                        end
                        else if (ex < hfic_pkg::EXP_ROUND)
                        begin
                            // subnormals and tiny values round to zero
                            fixed_next = 1'b1;
                        end
                        else if (ex >= hfic_pkg::INT_POINT)
                        begin
                            left_next = 1'b1;
                            cnt_next  = (hfic_pkg::CNT_W)'(ex - hfic_pkg::INT_POINT);
                        end
                        else
                        begin
                            cnt_next = (hfic_pkg::CNT_W)'(hfic_pkg::INT_POINT - ex);
                        end
                    end
                    else
                    begin
                        ctl.load_val = mag_in;
                        // integer zero packs to zero
                        if (cmd.value == '0)
                            fixed_next = 1'b1;
                    end
                end
            end

            hfic_pkg::ST_RUN:
            begin
                if (fixed_reg)
                begin
                    fin        = 1'b1;
                    fin_rsp    = fix_rsp_reg;
                    state_next = hfic_pkg::ST_IDLE;
                end
                else if (shifting)
                begin
                    if (op_reg == hfic_pkg::OP_H2I)
                    begin
                        ctl.shl  = left_reg;
                        ctl.shr  = ~left_reg;
                        cnt_next = cnt_reg - 1'b1;
                    end
                    else
                    begin
                        // normalize toward the top bit, counting shifts
                        ctl.shl  = 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                else
                begin
                    fin        = 1'b1;
                    state_next = hfic_pkg::ST_IDLE;
                    if (op_reg == hfic_pkg::OP_H2I)
                        fin_rsp.result = sign_reg ?
                                         (hfic_pkg::WORD_W)'(16'd0 - mag_out) : mag_out;
                    else
                        fin_rsp.result = {sign_reg, exp_out,
                                          stat.w[hfic_pkg::WORD_W-2 -: hfic_pkg::FRAC_W]};
                end
            end

            default:
            begin
                state_next = hfic_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= hfic_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        cnt_reg     <= cnt_next;
        op_reg      <= op_next;
        sign_reg    <= sign_next;
        left_reg    <= left_next;
        fixed_reg   <= fixed_next;
        fix_rsp_reg <= fix_rsp_next;
    end

    assign busy = (state_reg != hfic_pkg::ST_IDLE);

endmodule

// ===== hdl/half_float_int16_converter.sv =====
// top level of the half float / int16 converter
// Converts one 16-bit operand per command between an IEEE binary16 bit pattern and a
// two's complement int16: op 0 rounds a half to the nearest integer (ties to even) and
// saturates to 32767 / -32768 with overflow set for magnitudes of 2^15 and above,
// infinity and nan; op 1 turns an integer into a half, truncating dropped fraction bits.
// A command transfers on a clock edge with start high and busy low. The work is done by
// a single one-bit shifter stepped by a small sequencer, and the block stays busy through
// all shift steps: up to 11 right or 4 left steps for op 0, and up to 15 normalizing
// steps for op 1. Saturated, zero and tiny operands skip the shifting. The result
// transfer is shown for exactly one cycle with done high, in the first cycle with busy
// low again; the receiver cannot stall it, so it must take rsp whenever done is high.
// A new command may be issued in that same cycle.
module half_float_int16_converter (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  hfic_pkg::cmd_t cmd,
    output logic           busy,
    output logic           done,
    output hfic_pkg::rsp_t rsp
);

    hfic_pkg::shift_ctl_t  ctl;
    hfic_pkg::shift_stat_t stat;
    logic                  fin;
    hfic_pkg::rsp_t        fin_rsp;

    // result register and strobe
    logic           done_reg, done_next;
    hfic_pkg::rsp_t rsp_reg, rsp_next;

    // shared shifter holding the working mantissa
    hfic_shift_unit u_shift (
        .clk  (clk),
        .ctl  (ctl),
        .stat (stat)
    );

    // control: decode, step count, round and pack
    hfic_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .cmd     (cmd),
        .stat    (stat),
        .ctl     (ctl),
        .busy    (busy),
        .fin     (fin),
        .fin_rsp (fin_rsp)
    );

    always_comb
    begin
        done_next = fin;
        rsp_next  = fin ? fin_rsp : rsp_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= done_next;
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule
